@@ hw/rtl/rtr_pkg.sv @@
// Package for the rational time rescaler.
// Holds the transfer payload types, status codes and rounding mode codes.
package rtr_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_RATE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] RM_TRUNC = 2'd0;
    localparam logic [1:0] RM_FLOOR = 2'd1;
    localparam logic [1:0] RM_CEIL  = 2'd2;
    localparam logic [1:0] RM_NEAR  = 2'd3;

    typedef struct packed {
        logic signed [63:0] time_units;
        logic signed [31:0] src_rate_num;
        logic signed [31:0] src_rate_den;
        logic signed [31:0] dst_rate_num;
        logic signed [31:0] dst_rate_den;
        logic        [1:0]  round_mode;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] scaled_units;
        logic        [1:0]  status;
    } res_item_t;

    typedef struct packed {
        logic       valid;
        logic       bad;
        logic       neg;
        logic [1:0] mode;
    } ctl_t;

endpackage

@@ hw/rtl/rtr_front.sv @@
// Front end of the rescaler: rate check, magnitude, and the pipelined
// wide multiply that forms the dividend. Depends on rtr_pkg.
module rtr_front #(
    parameter int UNITS_WIDTH = 64,
    parameter int RATE_WIDTH  = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    ce,
    input  logic                                    in_valid,
    input  rtr_pkg::in_item_t                       in_item,
    output rtr_pkg::ctl_t                           ctl,
    output logic [2*RATE_WIDTH-3:0]                 div,
    output logic [UNITS_WIDTH+2*RATE_WIDTH-3:0]     num
);
    import rtr_pkg::*;

    localparam int UW = UNITS_WIDTH;
    localparam int RW = RATE_WIDTH;
    localparam int PW = 2*RW - 2;
    localparam int NW = UW + PW;
    localparam int MH = (UW + 1) / 2;
    localparam int AH = UW - MH;
    localparam int PH = RW - 1;

    logic [UW-1:0] units;
    logic [RW-1:0] rsn, rsd, rdn, rdd;
    logic          bad;

    ctl_t          ctl_a_reg, ctl_a_next;
    logic [UW-1:0] mag_a_reg, mag_a_next;
    logic [PW-1:0] prod_a_reg, prod_a_next;
    logic [PW-1:0] div_a_reg, div_a_next;

    ctl_t             ctl_b_reg;
    logic [PW-1:0]    div_b_reg;
    logic [MH+PH-1:0] pp00_reg;
    logic [MH+PH-1:0] pp01_reg;
    logic [AH+PH-1:0] pp10_reg;
    logic [AH+PH-1:0] pp11_reg;

    ctl_t          ctl_c_reg;
    logic [PW-1:0] div_c_reg;
    logic [NW-1:0] s0_reg, s1_reg;

    ctl_t          ctl_d_reg;
    logic [PW-1:0] div_d_reg;
    logic [NW-1:0] num_d_reg;

    always_comb
    begin
        units = in_item.time_units[UW-1:0];
        rsn   = in_item.src_rate_num[RW-1:0];
        rsd   = in_item.src_rate_den[RW-1:0];
        rdn   = in_item.dst_rate_num[RW-1:0];
        rdd   = in_item.dst_rate_den[RW-1:0];
        bad   = rsn[RW-1] || (rsn == '0) || rsd[RW-1] || (rsd == '0) ||
                rdn[RW-1] || (rdn == '0) || rdd[RW-1] || (rdd == '0);
        ctl_a_next.valid = in_valid;
        ctl_a_next.bad   = bad;
        ctl_a_next.neg   = units[UW-1];
        ctl_a_next.mode  = in_item.round_mode;
        mag_a_next  = units[UW-1] ? (~units + 1'b1) : units;
        prod_a_next = rsd[RW-2:0] * rdn[RW-2:0];
        div_a_next  = rsn[RW-2:0] * rdd[RW-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end
        else if (ce)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag_a_reg  <= mag_a_next;
            prod_a_reg <= prod_a_next;
            div_a_reg  <= div_a_next;

            div_b_reg <= div_a_reg;
            pp00_reg  <= mag_a_reg[MH-1:0]  * prod_a_reg[PH-1:0];
            pp01_reg  <= mag_a_reg[MH-1:0]  * prod_a_reg[PW-1:PH];
            pp10_reg  <= mag_a_reg[UW-1:MH] * prod_a_reg[PH-1:0];
            pp11_reg  <= mag_a_reg[UW-1:MH] * prod_a_reg[PW-1:PH];

            div_c_reg <= div_b_reg;
            s0_reg    <= NW'(pp00_reg) + (NW'(pp01_reg) << PH);
            s1_reg    <= NW'(pp10_reg) + (NW'(pp11_reg) << PH);

            div_d_reg <= div_c_reg;
            num_d_reg <= s0_reg + (s1_reg << MH);
        end
    end

    assign ctl = ctl_d_reg;
    assign div = div_d_reg;
    assign num = num_d_reg;

endmodule

@@ hw/rtl/rtr_div_cell.sv @@
// One restoring division step: develops one quotient bit per cell.
// Depends on rtr_pkg.
module rtr_div_cell #(
    parameter int UNITS_WIDTH = 64,
    parameter int RATE_WIDTH  = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    ce,
    input  rtr_pkg::ctl_t                           ctl_in,
    input  logic [2*RATE_WIDTH-3:0]                 div_in,
    input  logic [2*RATE_WIDTH-3:0]                 rem_in,
    input  logic [UNITS_WIDTH+2*RATE_WIDTH-3:0]     num_in,
    input  logic [UNITS_WIDTH:0]                    q_in,
    input  logic                                    sticky_in,
    output rtr_pkg::ctl_t                           ctl_out,
    output logic [2*RATE_WIDTH-3:0]                 div_out,
    output logic [2*RATE_WIDTH-3:0]                 rem_out,
    output logic [UNITS_WIDTH+2*RATE_WIDTH-3:0]     num_out,
    output logic [UNITS_WIDTH:0]                    q_out,
    output logic                                    sticky_out
);
    import rtr_pkg::*;

    localparam int UW = UNITS_WIDTH;
    localparam int PW = 2*RATE_WIDTH - 2;
    localparam int NW = UW + PW;

    ctl_t          ctl_reg;
    logic [PW-1:0] div_reg;
    logic [PW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg;
    logic [UW:0]   q_reg, q_next;
    logic          sticky_reg;
    logic [PW:0]   r2;
    logic          ge;

    always_comb
    begin
        r2       = {rem_in, num_in[NW-1]};
        ge       = r2 >= {1'b0, div_in};
        rem_next = ge ? PW'(r2 - {1'b0, div_in}) : r2[PW-1:0];
        q_next   = {q_in[UW-1:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (ce)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            div_reg    <= div_in;
            rem_reg    <= rem_next;
            num_reg    <= num_in << 1;
            q_reg      <= q_next;
            sticky_reg <= sticky_in | q_in[UW];
        end
    end

    assign ctl_out    = ctl_reg;
    assign div_out    = div_reg;
    assign rem_out    = rem_reg;
    assign num_out    = num_reg;
    assign q_out      = q_reg;
    assign sticky_out = sticky_reg;

endmodule

@@ hw/rtl/rational_time_rescaler_core.sv @@
// Rational time rescaler, top level: front multiply, chain of division cells, output register.
// Pipeline: 4 front stages, one restoring division cell per dividend bit, one output register.
// Throughput: one transfer per cycle; the whole pipeline holds while a result is stalled.
// Reset: rst_n asynchronously clears all valid bits; payload registers are not reset.
// Depends on rtr_pkg, rtr_front, rtr_div_cell.
module rational_time_rescaler_core #(
    parameter int UNITS_WIDTH = 64,
    parameter int RATE_WIDTH  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rtr_pkg::in_item_t   in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output rtr_pkg::res_item_t  res_item
);
    import rtr_pkg::*;

    localparam int UW = UNITS_WIDTH;
    localparam int PW = 2*RATE_WIDTH - 2;
    localparam int NW = UW + PW;

    logic ce;

    ctl_t          c_ctl [NW+1];
    logic [PW-1:0] c_div [NW+1];
    logic [PW-1:0] c_rem [NW+1];
    logic [NW-1:0] c_num [NW+1];
    logic [UW:0]   c_q   [NW+1];
    logic          c_sticky [NW+1];

    ctl_t          t_ctl;
    logic [PW-1:0] t_div, t_rem;
    logic [UW:0]   t_q;
    logic          t_sticky;
    logic          inc;
    logic [UW+1:0] qi;
    logic [UW+1:0] lim;
    logic [UW-1:0] mag_res;
    logic [UW-1:0] val_res;

    logic      valid_reg;
    res_item_t item_reg, item_next;

    assign ce       = !valid_reg || res_ready;
    assign in_ready = ce;

    rtr_front #(
        .UNITS_WIDTH(UNITS_WIDTH),
        .RATE_WIDTH (RATE_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_valid(in_valid),
        .in_item (in_item),
        .ctl     (c_ctl[0]),
        .div     (c_div[0]),
        .num     (c_num[0])
    );

    assign c_rem[0]    = '0;
    assign c_q[0]      = '0;
    assign c_sticky[0] = 1'b0;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        rtr_div_cell #(
            .UNITS_WIDTH(UNITS_WIDTH),
            .RATE_WIDTH (RATE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .ctl_in    (c_ctl[i]),
            .div_in    (c_div[i]),
            .rem_in    (c_rem[i]),
            .num_in    (c_num[i]),
            .q_in      (c_q[i]),
            .sticky_in (c_sticky[i]),
            .ctl_out   (c_ctl[i+1]),
            .div_out   (c_div[i+1]),
            .rem_out   (c_rem[i+1]),
            .num_out   (c_num[i+1]),
            .q_out     (c_q[i+1]),
            .sticky_out(c_sticky[i+1])
        );
    end

    always_comb
    begin
        t_ctl    = c_ctl[NW];
        t_div    = c_div[NW];
        t_rem    = c_rem[NW];
        t_q      = c_q[NW];
        t_sticky = c_sticky[NW];
        inc      = 1'b0;
        if (t_rem != '0)
        begin
            unique case (t_ctl.mode)
                RM_TRUNC: inc = 1'b0;
                RM_FLOOR: inc = t_ctl.neg;
                RM_CEIL:  inc = !t_ctl.neg;
                RM_NEAR:  inc = {t_rem, 1'b0} >= {1'b0, t_div};
                default:  inc = 1'b0;
            endcase
        end
        qi  = {1'b0, t_q} + (UW+2)'(inc);
        lim = (UW+2)'(1) << (UW - 1);
        if (!t_ctl.neg)
            lim = lim - 1'b1;
        mag_res = qi[UW-1:0];
        val_res = t_ctl.neg ? (~mag_res + 1'b1) : mag_res;
        if (t_ctl.bad)
        begin
            item_next.scaled_units = '0;
            item_next.status       = ST_BAD_RATE;
        end
        else if (t_sticky || (qi > lim))
        begin
            item_next.scaled_units = '0;
            item_next.status       = ST_OVERFLOW;
        end
        else
        begin
            item_next.scaled_units = 64'(signed'(val_res));
            item_next.status       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ce)
            valid_reg <= t_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            item_reg <= item_next;
    end

    assign res_valid = valid_reg;
    assign res_item  = item_reg;

endmodule

@@ hw/rtl/rtr_checker.sv @@
// Port-level checks for the rational time rescaler, bound to the top level.
// Depends on rtr_pkg and rational_time_rescaler_core.
module rtr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                res_valid,
    input logic                res_ready,
    input rtr_pkg::res_item_t  res_item
);
    import rtr_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.status == ST_OK || res_item.status == ST_BAD_RATE ||
                       res_item.status == ST_OVERFLOW))
        else $error("unknown status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status != ST_OK |-> res_item.scaled_units == '0)
        else $error("nonzero result on error");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!res_valid || res_ready))
        else $error("input ready does not follow output stall");

endmodule

bind rational_time_rescaler_core rtr_checker u_rtr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item)
);

@@ tb/sv/rational_time_rescaler_checker.sv @@
// Checker for the rational time rescaler: watches both transfer channels,
// predicts each result from the accepted input and compares in order.
// Depends on rtr_pkg.
`timescale 1ns / 100ps

module rational_time_rescaler_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  rtr_pkg::in_item_t  in_item,
    input  logic               res_valid,
    input  logic               res_ready,
    input  rtr_pkg::res_item_t res_item,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    import rtr_pkg::*;

    res_item_t expected_q[$];

    function automatic res_item_t rescale(input in_item_t it);
        res_item_t r;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] div;
        logic [63:0] mag;
        logic neg;
        logic bump;
        logic [127:0] lim;
        r.scaled_units = '0;
        r.status = ST_OK;
        bump = 1'b0;
        if (it.src_rate_num <= 0 || it.src_rate_den <= 0 ||
            it.dst_rate_num <= 0 || it.dst_rate_den <= 0)
        begin
            r.status = ST_BAD_RATE;
            return r;
        end
        neg = it.time_units[63];
        mag = neg ? -it.time_units : it.time_units;
        num = 128'(mag) * 128'(unsigned'(it.src_rate_den)) *
              128'(unsigned'(it.dst_rate_num));
        div = 128'(unsigned'(it.src_rate_num)) * 128'(unsigned'(it.dst_rate_den));
        quo = num / div;
        rem = num % div;
        if (rem != 0) begin
            case (it.round_mode)
                RM_FLOOR: bump = neg;
                RM_CEIL:  bump = !neg;
                RM_NEAR:  bump = (rem << 1) >= div;
                default:  bump = 1'b0;
            endcase
        end
        quo = quo + 128'(bump);
        lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (quo > lim) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.scaled_units = neg ? -quo[63:0] : quo[63:0];
        return r;
    endfunction

    initial begin
        fail_count = 0;
        result_count = 0;
    end

    assign pending_count = expected_q.size();

    always @(posedge clk) begin
        res_item_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                expected_q.push_back(rescale(in_item));
            if (res_valid && res_ready) begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %0d status %0d", $time,
                             res_item.scaled_units, res_item.status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.scaled_units !== res_item.scaled_units ||
                        want.status !== res_item.status)
                    begin
                        $display("%0t: expected %0d status %0d, got %0d status %0d",
                                 $time, want.scaled_units, want.status,
                                 res_item.scaled_units, res_item.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/rational_time_rescaler_core_tb.sv @@
// Testbench top for the rational time rescaler: drives directed and random
// timestamps under several idle patterns. Depends on rtr_pkg and the checker.
`timescale 1ns / 100ps

module rational_time_rescaler_core_tb;
    import rtr_pkg::*;

    localparam int LATENCY = 131;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic res_valid;
    logic res_ready;
    res_item_t res_item;
    int fail_count;
    int pending_count;
    int result_count;
    int cycle_count;
    int recv_stall_pct;
    int sent_count;

    rational_time_rescaler_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
    );

    rational_time_rescaler_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return -$urandom_range(1);
            3, 4: return $urandom_range(1000, 1);
            5: return {1'b0, 31'($urandom)};
            default: return $urandom_range(100000, 1);
        endcase
    endfunction

    function automatic logic signed [63:0] rand_units();
        case ($urandom_range(7))
            0: return {$urandom, $urandom};
            1: return 64'sh7fffffffffffffff - $urandom_range(3);
            2: return 64'sh8000000000000000 + $urandom_range(3);
            3: return $signed(64'($urandom_range(2000))) - 1000;
            default: return $signed({$urandom, $urandom}) >>> $urandom_range(63);
        endcase
    endfunction

    task automatic send(input in_item_t it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_one(input logic signed [63:0] u, input logic signed [31:0] sn,
                            input logic signed [31:0] sd, input logic signed [31:0] dn,
                            input logic signed [31:0] dd, input logic [1:0] m);
        in_item_t it;
        it = '{u, sn, sd, dn, dd, m};
        send(it, 0);
    endtask

    initial begin
        in_item_t it;
        int idle_pct;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        res_ready = 1'b0;
        recv_stall_pct = 0;
        cycle_count = 0;
        sent_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rounding of +-7/2, +-5/2 (halves), exact, bad rates, extremes
        send_one(7, 2, 1, 1, 1, RM_TRUNC);
        send_one(-7, 2, 1, 1, 1, RM_TRUNC);
        send_one(7, 2, 1, 1, 1, RM_FLOOR);
        send_one(-7, 2, 1, 1, 1, RM_FLOOR);
        send_one(7, 2, 1, 1, 1, RM_CEIL);
        send_one(-7, 2, 1, 1, 1, RM_CEIL);
        send_one(5, 2, 1, 1, 1, RM_NEAR);
        send_one(-5, 2, 1, 1, 1, RM_NEAR);
        send_one(7, 3, 1, 1, 1, RM_NEAR);
        send_one(9, 3, 1, 1, 1, RM_CEIL);
        send_one(5, 0, 1, 1, 1, RM_TRUNC);
        send_one(5, 1, -1, 1, 1, RM_TRUNC);
        send_one(5, 1, 1, 32'sh80000000, 1, RM_TRUNC);
        send_one(5, 1, 1, 1, 0, RM_TRUNC);
        send_one(64'sh7fffffffffffffff, 1, 2, 1, 1, RM_TRUNC);
        send_one(64'sh8000000000000000, 1, 1, 1, 1, RM_FLOOR);
        send_one(64'sh8000000000000000, 1, 2, 1, 1, RM_TRUNC);
        send_one(64'sh7fffffffffffffff, 1, 1, 1, 1, RM_CEIL);
        send_one(64'sh7fffffffffffffff, 2, 1, 1, 1, RM_NEAR);
        send_one(64'sh7fffffffffffffff, 1, 32'sh7fffffff, 32'sh7fffffff, 1, RM_NEAR);
        send_one(-1, 32'sh7fffffff, 1, 1, 32'sh7fffffff, RM_FLOOR);
        send_one(-1, 32'sh7fffffff, 1, 1, 32'sh7fffffff, RM_NEAR);
        send_one(0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, RM_CEIL);
        send_one(-1, 1, 1, 1, 1, RM_TRUNC);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 73) : 0;
            recv_stall_pct = (ph == 2) ? 73 : ((ph == 3) ? 15 : 0);
            for (int k = 0; k < 410; k++) begin
                it.time_units = rand_units();
                it.src_rate_num = rand_rate();
                it.src_rate_den = rand_rate();
                it.dst_rate_num = rand_rate();
                it.dst_rate_den = rand_rate();
                it.round_mode = 2'($urandom_range(3));
                send(it, idle_pct);
            end
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d timestamps across four idle/stall phases, %0d results checked.",
                 sent_count, result_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
